// File: rtl/core/spi_thermometer_device_defines.svh
// Assertion macros for the serial thermometer device.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef SPI_THERMOMETER_DEVICE_DEFINES_SVH
`define SPI_THERMOMETER_DEVICE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define STD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled during reset
`define STD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/core/spi_therm_pkg.sv
// Package for the serial thermometer device: request/response types, codes,
// register reset values and the conversion length table. No dependencies.
package spi_therm_pkg;

    localparam int TICKS_W = 20;

    typedef enum logic [2:0] {
        KIND_SELECT = 3'd0,
        KIND_SERIAL = 3'd1,
        KIND_DATA   = 3'd2,
        KIND_READ   = 3'd3,
        KIND_TICK   = 3'd4
    } kind_t;

    typedef enum logic [4:0] {
        CMD_NONE       = 5'b00001,
        CMD_READ_CONF  = 5'b00010,
        CMD_READ_LSB   = 5'b00100,
        CMD_READ_MSB   = 5'b01000,
        CMD_WRITE_CONF = 5'b10000
    } cmd_t;

    localparam logic [7:0] ADDR_READ_CONF  = 8'h00;
    localparam logic [7:0] ADDR_READ_LSB   = 8'h01;
    localparam logic [7:0] ADDR_READ_MSB   = 8'h02;
    localparam logic [7:0] ADDR_WRITE_CONF = 8'h80;

    localparam logic [7:0]  CONFIG_RESET = 8'h03;
    localparam logic [15:0] TEMP_RESET   = 16'h1910;
    localparam logic [7:0]  LSB_MASK     = 8'hf0;

    localparam int CFG_SD_BIT = 0;
    localparam int CFG_OS_BIT = 4;
    localparam logic [2:0] RES_CODE_MAX = 3'd4;

    localparam longint unsigned TICK_NS   = 64'd1000;
    localparam longint unsigned TICKS_MAX = 64'hFFFFF;

    localparam longint unsigned CONV_NS_8  = 64'd67500 * 64'd1000;
    localparam longint unsigned CONV_NS_9  = 64'd125 * 64'd1000000;
    localparam longint unsigned CONV_NS_10 = 64'd250 * 64'd1000000;
    localparam longint unsigned CONV_NS_11 = 64'd500 * 64'd1000000;
    localparam longint unsigned CONV_NS_12 = 64'd1000 * 64'd1000000;

    localparam longint unsigned RAW_8  = (CONV_NS_8 + TICK_NS - 64'd1) / TICK_NS;
    localparam longint unsigned RAW_9  = (CONV_NS_9 + TICK_NS - 64'd1) / TICK_NS;
    localparam longint unsigned RAW_10 = (CONV_NS_10 + TICK_NS - 64'd1) / TICK_NS;
    localparam longint unsigned RAW_11 = (CONV_NS_11 + TICK_NS - 64'd1) / TICK_NS;
    localparam longint unsigned RAW_12 = (CONV_NS_12 + TICK_NS - 64'd1) / TICK_NS;

    localparam logic [TICKS_W-1:0] TICKS_8  =
        (RAW_8 > TICKS_MAX) ? TICKS_MAX[TICKS_W-1:0] : RAW_8[TICKS_W-1:0];
    localparam logic [TICKS_W-1:0] TICKS_9  =
        (RAW_9 > TICKS_MAX) ? TICKS_MAX[TICKS_W-1:0] : RAW_9[TICKS_W-1:0];
    localparam logic [TICKS_W-1:0] TICKS_10 =
        (RAW_10 > TICKS_MAX) ? TICKS_MAX[TICKS_W-1:0] : RAW_10[TICKS_W-1:0];
    localparam logic [TICKS_W-1:0] TICKS_11 =
        (RAW_11 > TICKS_MAX) ? TICKS_MAX[TICKS_W-1:0] : RAW_11[TICKS_W-1:0];
    localparam logic [TICKS_W-1:0] TICKS_12 =
        (RAW_12 > TICKS_MAX) ? TICKS_MAX[TICKS_W-1:0] : RAW_12[TICKS_W-1:0];

    typedef struct packed {
        logic [2:0]  kind;
        logic        level;
        logic [7:0]  data_byte;
        logic [15:0] temperature_sample;
    } req_t;

    typedef struct packed {
        logic       read_valid;
        logic [7:0] read_byte;
        logic       converting;
    } rsp_t;

    // resolution codes of 4 and above behave as 12 bits
    function automatic logic [TICKS_W-1:0] conv_ticks(input logic [2:0] code);
        logic [TICKS_W-1:0] t;
        case (code)
            3'd0:    t = TICKS_8;
            3'd1:    t = TICKS_9;
            3'd2:    t = TICKS_10;
            3'd3:    t = TICKS_11;
            default: t = TICKS_12;
        endcase
        return t;
    endfunction

endpackage

// File: rtl/core/spi_therm_if.sv
// Request and response channel interfaces for the serial thermometer device.
// Valid/ready handshake; no package dependencies.
interface spi_therm_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic        level;
    logic [7:0]  data_byte;
    logic [15:0] temperature_sample;

    modport source (output valid, output kind, output level, output data_byte,
                    output temperature_sample, input ready);
    modport sink   (input valid, input kind, input level, input data_byte,
                    input temperature_sample, output ready);
endinterface

interface spi_therm_rsp_if;
    logic       valid;
    logic       ready;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       converting;

    modport source (output valid, output read_valid, output read_byte,
                    output converting, input ready);
    modport sink   (input valid, input read_valid, input read_byte,
                    input converting, output ready);
endinterface

// File: rtl/core/spi_therm_core.sv
// Device state and per-request update: bus command decode, config writes,
// conversion timer. Depends on spi_therm_pkg.
module spi_therm_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  spi_therm_pkg::req_t req,
    output spi_therm_pkg::rsp_t rsp
);
    import spi_therm_pkg::*;

    logic               select_reg, select_next;
    logic               serial_mode_reg, serial_mode_next;
    cmd_t               cmd_reg, cmd_next;
    logic               pending_reg, pending_next;
    logic [7:0]         pbyte_reg, pbyte_next;
    logic [7:0]         config_reg, config_next;
    logic [15:0]        temp_reg, temp_next;
    logic               start_reg, start_next;
    logic               running_reg, running_next;
    logic [TICKS_W-1:0] ticks_reg, ticks_next;
    logic [TICKS_W-1:0] ticks_dec;
    logic [2:0]         res_code;
    logic               new_sd, new_os;
    logic               rd_valid;
    logic [7:0]         rd_byte;

    assign res_code  = (config_reg[3:1] > RES_CODE_MAX) ? RES_CODE_MAX : config_reg[3:1];
    assign ticks_dec = (ticks_reg != '0) ? ticks_reg - TICKS_W'(1) : '0;
    assign new_sd    = req.data_byte[CFG_SD_BIT];
    assign new_os    = req.data_byte[CFG_OS_BIT];

    always_comb
    begin
        select_next      = select_reg;
        serial_mode_next = serial_mode_reg;
        cmd_next         = cmd_reg;
        pending_next     = pending_reg;
        pbyte_next       = pbyte_reg;
        config_next      = config_reg;
        temp_next        = temp_reg;
        start_next       = start_reg;
        running_next     = running_reg;
        ticks_next       = ticks_reg;
        rd_valid         = 1'b0;
        rd_byte          = 8'h00;

        if (accept)
        begin
            case (kind_t'(req.kind))
                KIND_SELECT:
                begin
                    select_next = req.level;
                    if (!req.level)
                    begin
                        cmd_next     = CMD_NONE;
                        pending_next = 1'b0;
                    end
                end
                KIND_SERIAL:
                begin
                    serial_mode_next = req.level;
                end
                KIND_DATA:
                begin
                    if (select_reg)
                    begin
                        if (cmd_reg == CMD_NONE)
                        begin
                            // address byte; unknown addresses leave everything as is
                            case (req.data_byte)
                                ADDR_READ_CONF:  cmd_next = CMD_READ_CONF;
                                ADDR_READ_LSB:   cmd_next = CMD_READ_LSB;
                                ADDR_READ_MSB:   cmd_next = CMD_READ_MSB;
                                ADDR_WRITE_CONF: cmd_next = CMD_WRITE_CONF;
                                default:         cmd_next = CMD_NONE;
                            endcase
                            if (cmd_next != CMD_NONE)
                            begin
                                pending_next = 1'b1;
                                pbyte_next   = 8'h00;
                            end
                        end
                        else
                        begin
                            pending_next = 1'b1;
                            case (cmd_reg)
                                CMD_READ_CONF: pbyte_next = config_reg;
                                CMD_READ_LSB:  pbyte_next = temp_reg[7:0] & LSB_MASK;
                                CMD_READ_MSB:  pbyte_next = temp_reg[15:8];
                                CMD_WRITE_CONF:
                                begin
                                    pbyte_next  = 8'h00;
                                    config_next = req.data_byte;
                                    if (config_reg[CFG_SD_BIT] && !new_sd)
                                        start_next = 1'b1;
                                    if (!config_reg[CFG_OS_BIT] && new_os && new_sd)
                                        start_next = 1'b1;
                                end
                                default:       pbyte_next = 8'h00;
                            endcase
                        end
                    end
                end
                KIND_READ:
                begin
                    if (select_reg && pending_reg)
                    begin
                        rd_valid     = 1'b1;
                        rd_byte      = pbyte_reg;
                        pending_next = 1'b0;
                    end
                end
                KIND_TICK:
                begin
                    if (start_reg)
                    begin
                        start_next   = 1'b0;
                        running_next = 1'b1;
                        ticks_next   = conv_ticks(res_code);
                    end
                    else if (running_reg)
                    begin
                        ticks_next = ticks_dec;
                        if (ticks_dec == '0)
                        begin
                            running_next = 1'b0;
                            temp_next    = req.temperature_sample;
                            if (!config_reg[CFG_SD_BIT])
                                start_next = 1'b1;
                            else if (config_reg[CFG_OS_BIT])
                                config_next[CFG_OS_BIT] = 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign rsp.read_valid = rd_valid;
    assign rsp.read_byte  = rd_byte;
    assign rsp.converting = start_next | running_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            select_reg      <= 1'b0;
            serial_mode_reg <= 1'b0;
            cmd_reg         <= CMD_NONE;
            pending_reg     <= 1'b0;
            pbyte_reg       <= 8'h00;
            config_reg      <= CONFIG_RESET;
            temp_reg        <= TEMP_RESET;
            start_reg       <= 1'b0;
            running_reg     <= 1'b0;
            ticks_reg       <= '0;
        end
        else
        begin
            select_reg      <= select_next;
            serial_mode_reg <= serial_mode_next;
            cmd_reg         <= cmd_next;
            pending_reg     <= pending_next;
            pbyte_reg       <= pbyte_next;
            config_reg      <= config_next;
            temp_reg        <= temp_next;
            start_reg       <= start_next;
            running_reg     <= running_next;
            ticks_reg       <= ticks_next;
        end
    end

endmodule

// File: rtl/core/spi_thermometer_device.sv
// Serial thermometer device, top level; uses spi_therm_pkg, spi_therm_if, spi_therm_core.
// Responses are registered in the output register, or in the skid while it is busy.
// Throughput: one request per cycle while ready is high; a two-entry output stage
// (register plus skid) keeps ready high while one response waits and drops it while two do.
// Reset (rst_n, async low): config 0x03, temperature 0x1910, no command,
// no conversion, output stage empty.
`include "spi_thermometer_device_defines.svh"

module spi_thermometer_device (
    input  logic             clk,
    input  logic             rst_n,
    spi_therm_req_if.sink    req,
    spi_therm_rsp_if.source  rsp
);
    import spi_therm_pkg::*;

    req_t req_word;
    rsp_t core_rsp;
    rsp_t out_reg, out_next;
    rsp_t skid_reg, skid_next;
    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    logic accept;
    logic out_fire;

    assign req_word.kind               = req.kind;
    assign req_word.level              = req.level;
    assign req_word.data_byte          = req.data_byte;
    assign req_word.temperature_sample = req.temperature_sample;

    assign req.ready = !skid_valid_reg;
    assign accept    = req.valid && !skid_valid_reg;
    assign out_fire  = out_valid_reg && rsp.ready;

    spi_therm_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .req    (req_word),
        .rsp    (core_rsp)
    );

    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = core_rsp;
                out_valid_next = accept;
            end
        end
        else if (accept)
        begin
            skid_next       = core_rsp;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_valid = out_reg.read_valid;
    assign rsp.read_byte  = out_reg.read_byte;
    assign rsp.converting = out_reg.converting;

    `STD_ASSERT_IMPLY(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `STD_ASSERT_NEXT(a_skid_holds, clk, rst_n, skid_valid_reg && !rsp.ready, skid_valid_reg && $stable(skid_reg))
    `STD_ASSERT_IMPLY(a_read_only_on_host_read, clk, rst_n, core_rsp.read_valid, accept && (req.kind == KIND_READ))
    `STD_ASSERT_NEXT(a_accept_fills_output, clk, rst_n, accept, out_valid_reg)

endmodule
